>>> hdl/bls_pkg.sv
package bls_pkg;

    // shared multiplier operand and accumulator widths
    localparam int MUL_W  = 25;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 52;

    // configuration register indexes
    localparam logic [3:0] CFG_GAIN_TILT       = 4'd0;
    localparam logic [3:0] CFG_GAIN_RATE       = 4'd1;
    localparam logic [3:0] CFG_GAIN_WHEEL      = 4'd2;
    localparam logic [3:0] CFG_TRIM_ALPHA      = 4'd3;
    localparam logic [3:0] CFG_MAX_TILT_DEV    = 4'd4;
    localparam logic [3:0] CFG_MAX_WHEEL_SPEED = 4'd5;
    localparam logic [3:0] CFG_STAND_ANGLE     = 4'd6;
    localparam logic [3:0] CFG_CURRENT_LIMIT   = 4'd7;

    // configuration reset values
    localparam logic [23:0] RST_GAIN_TILT       = 24'hE73375;  // -1625227
    localparam logic [23:0] RST_GAIN_RATE       = 24'hFD384A;  // -182198
    localparam logic [23:0] RST_GAIN_WHEEL      = 24'hFFF57A;  // -2694
    localparam logic [15:0] RST_TRIM_ALPHA      = 16'd66;
    localparam logic [22:0] RST_MAX_TILT_DEV    = 23'd11438;
    localparam logic [22:0] RST_MAX_WHEEL_SPEED = 23'd6862946;
    localparam logic [22:0] RST_STAND_ANGLE     = 23'd3431;
    localparam logic [22:0] RST_CURRENT_LIMIT   = 23'd524288;

    typedef struct packed {
        logic [31:0]        time_ms;
        logic signed [23:0] tilt;
        logic signed [23:0] tilt_rate;
        logic signed [23:0] wheel_speed_raw;
    } in_item_t;

    typedef struct packed {
        logic signed [23:0] drive_target;
        logic               mode;
        logic signed [23:0] trim;
        logic               fault;
        logic               updated;
    } out_item_t;

    // control of the shared multiply-accumulate unit
    typedef struct packed {
        logic load;   // register op_a * op_b
        logic acc;    // fold the registered product into the accumulator
        logic clear;  // start the accumulator from the product
        logic neg;    // subtract instead of add
    } mac_ctrl_t;

endpackage

>>> hdl/balance_lqr_supervisor.sv
// Balancing supervisor with state-feedback drive.
// Input channel in_valid/in_ready/in_data carries one sensor beat: tick,
// tilt, tilt rate and raw wheel speed. Output channel out_valid/out_ready/
// out_data returns exactly one result beat per input beat, in order.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); write it
// only while no beat is in flight. Indexes beyond 7 are ignored.
// One beat is worked at a time: in_ready is high only while the sequencer
// is idle. A skipped, waiting or dropout beat goes from S_CHECK straight to
// S_DONE and the output register; an enabled beat runs the trim filter and the
// feedback sum through the one shared 25x25 multiply-accumulate unit, five
// products in nine steps, before S_DONE. The next beat is taken once the
// sequencer is back in S_IDLE after the result is loaded. When the receiver
// stalls the result stays in the output register and a finished result waits
// in the sequencer until it is free.
// Reset clears mode, trim, target, stand timer and tick history and loads
// the default gains and limits; no beat is pending after reset.
module balance_lqr_supervisor #(
    parameter int STAND_MS = 2000
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bls_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output bls_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic [3:0]         cfg_index,
    input  logic [23:0]        cfg_data
);
    import bls_pkg::*;

    localparam int RND_W = ACC_W - 16;
    localparam logic [31:0] STAND_LIMIT = 32'(STAND_MS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_TRIM_A,
        S_TRIM_B,
        S_TRIM_C,
        S_TRIM_R,
        S_FB_A,
        S_FB_B,
        S_FB_C,
        S_FB_D,
        S_FB_R,
        S_DONE
    } state_t;

    // configuration registers
    logic signed [23:0] gain_tilt_reg;
    logic signed [23:0] gain_rate_reg;
    logic signed [23:0] gain_wheel_reg;
    logic [15:0]        trim_alpha_reg;
    logic [22:0]        max_tilt_dev_reg;
    logic [22:0]        max_wheel_speed_reg;
    logic [22:0]        stand_angle_reg;
    logic [22:0]        current_limit_reg;

    // controller state
    state_t             state_reg;
    logic               mode_reg;
    logic signed [23:0] trim_reg;
    logic [31:0]        stand_start_reg;
    logic               stand_timing_reg;
    logic [31:0]        last_time_reg;
    logic               have_last_reg;
    logic signed [23:0] target_reg;
    logic               fault_reg;
    logic               updated_reg;
    in_item_t           item_reg;
    logic               out_valid_reg;
    out_item_t          out_data_reg;

    // datapath
    mac_ctrl_t                mac_ctrl;
    logic signed [MUL_W-1:0]  op_a;
    logic signed [MUL_W-1:0]  op_b;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  acc_bias;
    logic signed [RND_W-1:0]  acc_rnd;
    logic signed [RND_W-1:0]  lim_ext;
    logic signed [23:0]       drive_clamped;
    logic signed [24:0]       tilt_ext;
    logic signed [24:0]       rate_ext;
    logic signed [24:0]       wheel;
    logic signed [24:0]       dev;
    logic signed [24:0]       tc;
    logic signed [24:0]       max_dev_ext;
    logic signed [24:0]       max_wheel_ext;
    logic signed [24:0]       stand_ext;
    logic [16:0]              one_minus_alpha;
    logic                     skip;
    logic                     dropout;
    logic                     standing;
    logic                     stand_elapsed;
    logic                     out_free;

    bls_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .op_a  (op_a),
        .op_b  (op_b),
        .acc   (acc)
    );

    // decisions on the held beat
    always_comb
    begin
        tilt_ext      = {item_reg.tilt[23], item_reg.tilt};
        rate_ext      = {item_reg.tilt_rate[23], item_reg.tilt_rate};
        wheel         = -{item_reg.wheel_speed_raw[23], item_reg.wheel_speed_raw};
        dev           = tilt_ext - {trim_reg[23], trim_reg};
        tc            = dev;
        max_dev_ext   = {2'b00, max_tilt_dev_reg};
        max_wheel_ext = {2'b00, max_wheel_speed_reg};
        stand_ext     = {2'b00, stand_angle_reg};
        skip          = !have_last_reg || (item_reg.time_ms == last_time_reg);
        dropout       = (dev > max_dev_ext) || (dev < -max_dev_ext)
                        || (wheel > max_wheel_ext) || (wheel < -max_wheel_ext);
        standing      = (tilt_ext < stand_ext) && (tilt_ext > -stand_ext);
        stand_elapsed = (item_reg.time_ms - stand_start_reg) > STAND_LIMIT;
        out_free      = !out_valid_reg || out_ready;
    end

    // operand selection and unit control per step
    always_comb
    begin
        one_minus_alpha = 17'h10000 - {1'b0, trim_alpha_reg};
        op_a     = '0;
        op_b     = '0;
        mac_ctrl = '0;
        case (state_reg)
            S_TRIM_A:
            begin
                op_a          = {8'b0, one_minus_alpha};
                op_b          = {trim_reg[23], trim_reg};
                mac_ctrl.load = 1'b1;
            end
            S_TRIM_B:
            begin
                op_a           = {9'b0, trim_alpha_reg};
                op_b           = tilt_ext;
                mac_ctrl.load  = 1'b1;
                mac_ctrl.acc   = 1'b1;
                mac_ctrl.clear = 1'b1;
            end
            S_TRIM_C:
            begin
                mac_ctrl.acc = 1'b1;
            end
            S_FB_A:
            begin
                op_a          = {gain_tilt_reg[23], gain_tilt_reg};
                op_b          = tc;
                mac_ctrl.load = 1'b1;
            end
            S_FB_B:
            begin
                op_a           = {gain_rate_reg[23], gain_rate_reg};
                op_b           = rate_ext;
                mac_ctrl.load  = 1'b1;
                mac_ctrl.acc   = 1'b1;
                mac_ctrl.clear = 1'b1;
                mac_ctrl.neg   = 1'b1;
            end
            S_FB_C:
            begin
                op_a          = {gain_wheel_reg[23], gain_wheel_reg};
                op_b          = wheel;
                mac_ctrl.load = 1'b1;
                mac_ctrl.acc  = 1'b1;
                mac_ctrl.neg  = 1'b1;
            end
            S_FB_D:
            begin
                mac_ctrl.acc = 1'b1;
                mac_ctrl.neg = 1'b1;
            end
            default:
            begin
                mac_ctrl = '0;
            end
        endcase
    end

    // round to nearest toward plus infinity at half, then saturate
    always_comb
    begin
        acc_bias = acc + ACC_W'(32768);
        acc_rnd  = acc_bias[ACC_W-1:16];
        lim_ext  = {{(RND_W - 23){1'b0}}, current_limit_reg};
        if (acc_rnd > lim_ext)
        begin
            drive_clamped = {1'b0, current_limit_reg};
        end
        else if (acc_rnd < -lim_ext)
        begin
            drive_clamped = -{1'b0, current_limit_reg};
        end
        else
        begin
            drive_clamped = acc_rnd[23:0];
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_tilt_reg       <= RST_GAIN_TILT;
            gain_rate_reg       <= RST_GAIN_RATE;
            gain_wheel_reg      <= RST_GAIN_WHEEL;
            trim_alpha_reg      <= RST_TRIM_ALPHA;
            max_tilt_dev_reg    <= RST_MAX_TILT_DEV;
            max_wheel_speed_reg <= RST_MAX_WHEEL_SPEED;
            stand_angle_reg     <= RST_STAND_ANGLE;
            current_limit_reg   <= RST_CURRENT_LIMIT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GAIN_TILT:       gain_tilt_reg       <= cfg_data;
                CFG_GAIN_RATE:       gain_rate_reg       <= cfg_data;
                CFG_GAIN_WHEEL:      gain_wheel_reg      <= cfg_data;
                CFG_TRIM_ALPHA:      trim_alpha_reg      <= cfg_data[15:0];
                CFG_MAX_TILT_DEV:    max_tilt_dev_reg    <= cfg_data[22:0];
                CFG_MAX_WHEEL_SPEED: max_wheel_speed_reg <= cfg_data[22:0];
                CFG_STAND_ANGLE:     stand_angle_reg     <= cfg_data[22:0];
                CFG_CURRENT_LIMIT:   current_limit_reg   <= cfg_data[22:0];
                default:             ;
            endcase
        end
    end

    // sequencer, controller state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            mode_reg         <= 1'b0;
            trim_reg         <= '0;
            stand_start_reg  <= '0;
            stand_timing_reg <= 1'b0;
            last_time_reg    <= '0;
            have_last_reg    <= 1'b0;
            target_reg       <= '0;
            fault_reg        <= 1'b0;
            updated_reg      <= 1'b0;
            item_reg         <= '0;
            out_valid_reg    <= 1'b0;
            out_data_reg     <= '0;
        end
        else
        begin
            // a beat loaded in S_DONE replaces the one leaving
            if (out_valid_reg && out_ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        item_reg  <= in_data;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    last_time_reg <= item_reg.time_ms;
                    have_last_reg <= 1'b1;
                    fault_reg     <= !skip && mode_reg && dropout;
                    updated_reg   <= !skip;
                    state_reg     <= (!skip && mode_reg && !dropout) ? S_TRIM_A : S_DONE;
                    if (!skip)
                    begin
                        if (mode_reg)
                        begin
                            if (dropout)
                            begin
                                mode_reg   <= 1'b0;
                                target_reg <= '0;
                            end
                        end
                        else
                        begin
                            trim_reg   <= '0;
                            target_reg <= '0;
                            if (standing)
                            begin
                                if (!stand_timing_reg)
                                begin
                                    stand_timing_reg <= 1'b1;
                                    stand_start_reg  <= item_reg.time_ms;
                                end
                                else if (stand_elapsed)
                                begin
                                    mode_reg         <= 1'b1;
                                    stand_timing_reg <= 1'b0;
                                    stand_start_reg  <= '0;
                                end
                            end
                            else
                            begin
                                stand_timing_reg <= 1'b0;
                                stand_start_reg  <= '0;
                            end
                        end
                    end
                end
                S_TRIM_A: state_reg <= S_TRIM_B;
                S_TRIM_B: state_reg <= S_TRIM_C;
                S_TRIM_C: state_reg <= S_TRIM_R;
                S_TRIM_R:
                begin
                    trim_reg  <= acc_rnd[23:0];
                    state_reg <= S_FB_A;
                end
                S_FB_A: state_reg <= S_FB_B;
                S_FB_B: state_reg <= S_FB_C;
                S_FB_C: state_reg <= S_FB_D;
                S_FB_D: state_reg <= S_FB_R;
                S_FB_R:
                begin
                    target_reg <= drive_clamped;
                    state_reg  <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_data_reg.drive_target <= target_reg;
                        out_data_reg.mode         <= mode_reg;
                        out_data_reg.trim         <= trim_reg;
                        out_data_reg.fault        <= fault_reg;
                        out_data_reg.updated      <= updated_reg;
                        out_valid_reg             <= 1'b1;
                        state_reg                 <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> hdl/bls_mac.sv
module bls_mac (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bls_pkg::mac_ctrl_t                ctrl,
    input  logic signed [bls_pkg::MUL_W-1:0]  op_a,
    input  logic signed [bls_pkg::MUL_W-1:0]  op_b,
    output logic signed [bls_pkg::ACC_W-1:0]  acc
);
    import bls_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  base;

    // multiply stage
    assign prod_next = op_a * op_b;

    // accumulate stage
    always_comb
    begin
        prod_ext = {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        base     = ctrl.clear ? '0 : acc_reg;
        acc_next = ctrl.neg ? (base - prod_ext) : (base + prod_ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc)
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            prod_reg <= prod_next;
        end
    end

    assign acc = acc_reg;

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import bls_pkg::*;

    localparam int STAND_MS         = 2000;
    localparam int LIMIT_CYCLES     = 500000;
    localparam int HOLD_CYCLES      = 300;
    localparam int SHOWN_MISMATCHES = 10;

    localparam logic MODE_WAITING = 1'b0;
    localparam logic MODE_ENABLED = 1'b1;

    // an index past the register list, must be ignored
    localparam logic [3:0] CFG_UNMAPPED = 4'd13;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    in_item_t    in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;
    logic        cfg_we    = 1'b0;
    logic [3:0]  cfg_index = '0;
    logic [23:0] cfg_data  = '0;

    balance_lqr_supervisor #(
        .STAND_MS(STAND_MS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // predictor copy of the configuration
    longint k_tilt, k_rate, k_wheel, alpha;
    longint dev_lim, wheel_lim, band, cur_lim;

    // predictor copy of the supervisor state
    logic        mdl_mode;
    longint      mdl_trim;
    longint      mdl_target;
    logic [31:0] stand_start;
    logic        stand_timing;
    logic [31:0] last_tick;
    logic        have_tick;

    out_item_t   pending_results[$];
    out_item_t   want;
    logic [31:0] tick        = '0;
    int          fail_count  = 0;
    int          cycles      = 0;
    int          hold_token  = 0;
    int          hold_seen   = 0;
    int          hold_left   = 0;
    int          stall_left  = 0;
    int          rx_roll;
    logic        rx_idle_on  = 1'b1;
    bit          tx_idle_on  = 1'b1;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic signed [23:0] sat24(longint v);
        if (v > 8388607)
            return 24'sh7FFFFF;
        if (v < -8388608)
            return 24'sh800000;
        return 24'(v);
    endfunction

    // uniform in [-m, m]
    function automatic longint rand_span(longint m);
        return longint'($urandom_range(0, 32'(2 * m))) - m;
    endfunction

    function automatic void reset_model();
        k_tilt       = longint'($signed(RST_GAIN_TILT));
        k_rate       = longint'($signed(RST_GAIN_RATE));
        k_wheel      = longint'($signed(RST_GAIN_WHEEL));
        alpha        = longint'(RST_TRIM_ALPHA);
        dev_lim      = longint'(RST_MAX_TILT_DEV);
        wheel_lim    = longint'(RST_MAX_WHEEL_SPEED);
        band         = longint'(RST_STAND_ANGLE);
        cur_lim      = longint'(RST_CURRENT_LIMIT);
        mdl_mode     = MODE_WAITING;
        mdl_trim     = 0;
        mdl_target   = 0;
        stand_start  = '0;
        stand_timing = 1'b0;
        last_tick    = '0;
        have_tick    = 1'b0;
    endfunction

    function automatic void apply_reg(logic [3:0] idx, logic [23:0] data);
        case (idx)
            CFG_GAIN_TILT:       k_tilt    = longint'($signed(data));
            CFG_GAIN_RATE:       k_rate    = longint'($signed(data));
            CFG_GAIN_WHEEL:      k_wheel   = longint'($signed(data));
            CFG_TRIM_ALPHA:      alpha     = longint'(data[15:0]);
            CFG_MAX_TILT_DEV:    dev_lim   = longint'(data[22:0]);
            CFG_MAX_WHEEL_SPEED: wheel_lim = longint'(data[22:0]);
            CFG_STAND_ANGLE:     band      = longint'(data[22:0]);
            CFG_CURRENT_LIMIT:   cur_lim   = longint'(data[22:0]);
            default: ;
        endcase
    endfunction

    // expected result of one sensor beat, advances the predictor state
    function automatic out_item_t supervise_beat(in_item_t it);
        out_item_t   res;
        longint      tilt, rate, wheel, acc, tc, sum, u;
        logic [31:0] held;
        logic        skip;
        logic        fault;
        tilt      = longint'($signed(it.tilt));
        rate      = longint'($signed(it.tilt_rate));
        wheel     = -longint'($signed(it.wheel_speed_raw));
        skip      = !have_tick || (it.time_ms == last_tick);
        last_tick = it.time_ms;
        have_tick = 1'b1;
        fault     = 1'b0;
        if (!skip)
        begin
            if (mdl_mode == MODE_ENABLED)
            begin
                // dropout on tilt deviation from the old trim or on wheel speed
                if (mag(tilt - mdl_trim) > dev_lim || mag(wheel) > wheel_lim)
                begin
                    mdl_mode   = MODE_WAITING;
                    mdl_target = 0;
                    fault      = 1'b1;
                end
                else
                begin
                    acc      = (65536 - alpha) * mdl_trim + alpha * tilt;
                    mdl_trim = (acc + 32768) >>> 16;
                    tc       = tilt - mdl_trim;
                    sum      = k_tilt * tc + k_rate * rate + k_wheel * wheel;
                    u        = (32768 - sum) >>> 16;
                    if (u > cur_lim)
                        u = cur_lim;
                    if (u < -cur_lim)
                        u = -cur_lim;
                    mdl_target = u;
                end
            end
            else
            begin
                mdl_trim   = 0;
                mdl_target = 0;
                if (mag(tilt) < band)
                begin
                    if (!stand_timing)
                    begin
                        stand_timing = 1'b1;
                        stand_start  = it.time_ms;
                    end
                    else
                    begin
                        held = it.time_ms - stand_start;
                        if (held > 32'(STAND_MS))
                        begin
                            mdl_mode     = MODE_ENABLED;
                            stand_timing = 1'b0;
                            stand_start  = '0;
                        end
                    end
                end
                else
                begin
                    stand_timing = 1'b0;
                    stand_start  = '0;
                end
            end
        end
        res.drive_target = mdl_target[23:0];
        res.mode         = mdl_mode;
        res.trim         = mdl_trim[23:0];
        res.fault        = fault;
        res.updated      = !skip;
        return res;
    endfunction

    // receiver: random stalls, optional long hold-off counted here
    always @(posedge clk)
    begin
        if (hold_token != hold_seen)
        begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (!rx_idle_on)
            out_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 70)
                out_ready <= 1'b1;
            else
            begin
                stall_left = (rx_roll < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
                out_ready <= 1'b0;
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= SHOWN_MISMATCHES)
                    $display("unexpected result beat: %p", out_data);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.drive_target !== want.drive_target ||
                    out_data.mode !== want.mode || out_data.trim !== want.trim ||
                    out_data.fault !== want.fault || out_data.updated !== want.updated)
                begin
                    fail_count++;
                    if (fail_count <= SHOWN_MISMATCHES)
                    begin
                        $write("mismatch: expected target=%0d mode=%0b trim=%0d ",
                               want.drive_target, want.mode, want.trim);
                        $write("fault=%0b upd=%0b, ", want.fault, want.updated);
                        $write("got target=%0d mode=%0b trim=%0d ",
                               out_data.drive_target, out_data.mode, out_data.trim);
                        $display("fault=%0b upd=%0b", out_data.fault, out_data.updated);
                    end
                end
            end
        end
    end

    function automatic int tx_gap();
        int r;
        if (!tx_idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // send one sensor beat, tick advanced by dt
    task automatic send_beat(input logic [31:0] dt, input logic signed [23:0] tilt,
                             input logic signed [23:0] rate,
                             input logic signed [23:0] wheel);
        in_item_t it;
        int       gap;
        tick               = tick + dt;
        it.time_ms         = tick;
        it.tilt            = tilt;
        it.tilt_rate       = rate;
        it.wheel_speed_raw = wheel;
        gap                = tx_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(supervise_beat(it));
    endtask

    // stop offering and let every expected result come back
    task automatic wait_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [23:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        apply_reg(idx, data);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic load_config(input logic [23:0] gt, input logic [23:0] gr,
                               input logic [23:0] gw, input logic [23:0] al,
                               input logic [23:0] dv, input logic [23:0] ws,
                               input logic [23:0] sa, input logic [23:0] cl);
        write_reg(CFG_GAIN_TILT, gt);
        write_reg(CFG_GAIN_RATE, gr);
        write_reg(CFG_GAIN_WHEEL, gw);
        write_reg(CFG_TRIM_ALPHA, al);
        write_reg(CFG_MAX_TILT_DEV, dv);
        write_reg(CFG_MAX_WHEEL_SPEED, ws);
        write_reg(CFG_STAND_ANGLE, sa);
        write_reg(CFG_CURRENT_LIMIT, cl);
    endtask

    // mostly stand-up then balance sequences, some noise and dropouts
    task automatic run_session(input int count);
        int          r;
        logic [31:0] dt;
        longint      tilt, rate, wheel;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                // noise: any fields, often a repeated tick
                case ($urandom_range(0, 2))
                    0: dt = '0;
                    1: dt = 32'd1;
                    default: dt = $urandom;
                endcase
                send_beat(dt, 24'($urandom), 24'($urandom), 24'($urandom));
            end
            else if (mdl_mode == MODE_WAITING)
            begin
                if (band > 0 && $urandom_range(0, 99) >= 5)
                    tilt = rand_span(band - 1);
                else
                    tilt = ($urandom_range(0, 1) ? 1 : -1) * (band + $urandom_range(0, 5000));
                send_beat($urandom_range(150, 700), sat24(tilt), 24'($urandom),
                          24'($urandom));
            end
            else
            begin
                r     = $urandom_range(0, 99);
                tilt  = mdl_trim + rand_span(dev_lim);
                wheel = -rand_span(wheel_lim);
                if (r < 5)
                    tilt = longint'($signed(24'($urandom)));
                else if (r < 9)
                    wheel = ($urandom_range(0, 1) ? 1 : -1)
                            * (wheel_lim + 1 + $urandom_range(0, 1000));
                rate = $urandom_range(0, 1) ? longint'($signed(24'($urandom)))
                                            : rand_span(50000);
                send_beat($urandom_range(1, 20), sat24(tilt), sat24(rate), sat24(wheel));
            end
        end
    endtask

    // skipped beats, stand timing across a tick wrap, saturation, dropouts
    task automatic test_directed();
        tick = 32'hFFFF_FC00;
        // no earlier tick, then a repeated tick
        send_beat(0, 24'sh7FFFFF, 24'sh800000, 24'sh800000);
        send_beat(0, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF);
        // stand timer starts, holds exactly STAND_MS, then enables
        send_beat(1, 0, 0, 0);
        send_beat(1000, 3430, 0, 0);
        send_beat(1000, -3430, 0, 0);
        send_beat(1, 0, 0, 0);
        // balancing, both saturation directions, repeated tick in enabled
        send_beat(1, 1000, 5000, -300);
        send_beat(1, 0, 24'sh7FFFFF, 0);
        send_beat(1, 0, 24'sh800000, 0);
        send_beat(0, 0, 0, 0);
        // deviation and wheel speed exactly on their bounds stay enabled
        send_beat(1, sat24(mdl_trim + dev_lim), 0, sat24(-wheel_lim));
        // deviation just past the bound drops out
        send_beat(1, sat24(mdl_trim - dev_lim - 1), 0, 0);
        // tilt on the stand band edge does not count as standing
        send_beat(1, 3431, 0, 0);
        send_beat(1, -3431, 0, 0);
        send_beat(1, 0, 0, 0);
        send_beat(2001, 0, 0, 0);
        // most negative raw wheel speed always drops out
        send_beat(1, 0, 0, 24'sh800000);
        send_beat(1, 0, 0, 0);
        send_beat(2001, 0, 0, 0);
        // wheel speed just past its bound
        send_beat(1, 0, 0, sat24(-wheel_lim - 1));
        wait_results();
    endtask

    // largest and smallest settings, then raw random register data, then an unmapped index
    task automatic test_config_extremes();
        load_config(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h00FFFF,
                    24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        run_session(25);
        wait_results();
        load_config(24'h800000, 24'h800000, 24'h800000, 24'h000000,
                    24'h000000, 24'h000000, 24'h000001, 24'h000000);
        run_session(25);
        wait_results();
        load_config(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                    24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
        run_session(25);
        wait_results();
        write_reg(CFG_UNMAPPED, 24'($urandom));
        run_session(25);
        wait_results();
    endtask

    // long receiver hold-off with the sender pushing, then a full drain pause
    task automatic test_backpressure();
        load_config(RST_GAIN_TILT, RST_GAIN_RATE, RST_GAIN_WHEEL, 24'(RST_TRIM_ALPHA),
                    24'(RST_MAX_TILT_DEV), 24'(RST_MAX_WHEEL_SPEED),
                    24'(RST_STAND_ANGLE), 24'(RST_CURRENT_LIMIT));
        tx_idle_on = 1'b0;
        hold_token <= hold_token + 1;
        run_session(30);
        wait_results();
        hold_token <= hold_token + 1;
        run_session(30);
        tx_idle_on = 1'b1;
        wait_results();
    endtask

    // random settings per phase, idling switched on and off
    task automatic test_random();
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph % 2 == 0)
                load_config(24'($urandom), 24'($urandom), 24'($urandom),
                            24'($urandom_range(0, 65535)),
                            24'($urandom_range(500, 300000)),
                            24'($urandom_range(1000, 8388607)),
                            24'($urandom_range(1, 50000)),
                            24'($urandom_range(0, 8388607)));
            else
                load_config(24'(rand_span(300000)), 24'(rand_span(300000)),
                            24'(rand_span(300000)), 24'($urandom_range(0, 4000)),
                            24'($urandom_range(500, 300000)),
                            24'($urandom_range(1000, 8388607)),
                            24'($urandom_range(1, 50000)),
                            24'($urandom_range(0, 8388607)));
            rx_idle_on <= ($urandom_range(0, 3) != 0);
            tx_idle_on = ($urandom_range(0, 3) != 0);
            run_session(30);
            wait_results();
        end
    endtask

    initial
    begin
        reset_model();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config_extremes();
        test_backpressure();
        test_random();
        wait_results();
        repeat (20) @(posedge clk);
        fail_count += pending_results.size();
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
